FILE: hw/rtl/csu_pkg.sv
package csu_pkg;

  // element width default; the ports follow the top-level parameter
  localparam int unsigned ELEM_BITS_DEF = 16;

  // accumulators and result
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned SIM_W      = 16;
  localparam int unsigned FRAC_SHIFT = 16;               // radicand scale, 8 frac bits in root
  localparam int unsigned RAD_W      = ACC_W + FRAC_SHIFT; // 64-bit radicand
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned DEN_W      = 2 * ROOT_W;
  localparam int unsigned DIV_SCALE  = 32;               // dividend = mag * 2^32
  localparam int unsigned QUO_W      = 64;
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned DIV_STEPS  = ACC_W + DIV_SCALE;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  localparam logic [RAD_W-1:0] SQ_BIT_INIT = {2'b01, {(RAD_W-2){1'b0}}};
  localparam logic [QUO_W-1:0] QUO_POS_MAX = QUO_W'(32767);
  localparam logic [QUO_W-1:0] QUO_NEG_MAX = QUO_W'(32768);
  localparam logic [SIM_W-1:0] SIM_POS_SAT = {1'b0, {(SIM_W-1){1'b1}}};
  localparam logic [SIM_W-1:0] SIM_NEG_SAT = {1'b1, {(SIM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_ACCUM,
    S_DRAIN,
    S_CHECK,
    S_SQRT,
    S_MUL,
    S_DIV,
    S_ROUND
  } state_t;

  typedef struct packed {
    logic take;      // input transaction this cycle
    logic load;      // capture sums into finish unit, clear sums
    logic sq_step;   // one root bit on both lanes
    logic mul;       // form the denominator
    logic div_step;  // one quotient bit
    logic emit;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic zero;      // a sum of squares is zero
  } status_t;

endpackage

FILE: hw/rtl/csu_in_if.sv
interface csu_in_if #(
  parameter int unsigned ELEM_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [ELEM_BITS-1:0] a_value;
  logic signed [ELEM_BITS-1:0] b_value;
  logic                        last;

  modport source (output valid, a_value, b_value, last, input ready);
  modport sink   (input valid, a_value, b_value, last, output ready);
endinterface

FILE: hw/rtl/csu_out_if.sv
interface csu_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] similarity;
  logic               zero_norm;

  modport source (output valid, similarity, zero_norm, input ready);
  modport sink   (input valid, similarity, zero_norm, output ready);
endinterface

FILE: hw/rtl/csu_ctrl.sv
module csu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  csu_pkg::status_t  status,
  output csu_pkg::cmd_t     cmd
);
  import csu_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACCUM;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_ACCUM: begin
        if (in_valid && in_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_CHECK;
      S_CHECK: begin
        cnt_nxt   = '0;
        state_nxt = status.zero ? S_ROUND : S_SQRT;
      end
      S_SQRT: begin
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_ROUND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ROUND: begin
        if (out_free) begin
          state_nxt     = S_ACCUM;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_ACCUM;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      S_ACCUM: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_DRAIN: ;
      S_CHECK: cmd.load     = 1'b1;
      S_SQRT:  cmd.sq_step  = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_ROUND: cmd.emit     = out_free;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/csu_datapath.sv
module csu_datapath #(
  parameter int unsigned ELEM_BITS = csu_pkg::ELEM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [ELEM_BITS-1:0]     a_value,
  input  logic signed [ELEM_BITS-1:0]     b_value,
  input  csu_pkg::cmd_t                   cmd,
  output csu_pkg::status_t                status,
  output logic signed [csu_pkg::SIM_W-1:0] similarity,
  output logic                            zero_norm
);
  import csu_pkg::*;

  localparam int unsigned PROD_W = 2 * ELEM_BITS;
  localparam int unsigned SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  // product stage
  logic signed [PROD_W-1:0] prod_ab_r, prod_aa_r, prod_bb_r;
  logic                     p_valid_r;

  // accumulators
  logic signed [ACC_W-1:0] dot_r, dot_nxt;
  logic signed [ACC_W-1:0] ssq1_r, ssq1_nxt;
  logic signed [ACC_W-1:0] ssq2_r, ssq2_nxt;

  // root lanes
  logic [RAD_W-1:0] x1_r, x2_r, res1_r, res2_r, bit_r;
  logic [RAD_W-1:0] t1, t2, x1_nxt, x2_nxt, res1_nxt, res2_nxt;

  // divider
  logic [ACC_W-1:0] mag_r;
  logic             neg_r;
  logic             zero_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;

  // rounding
  logic [QUO_W:0]   quo_inc;
  logic [QUO_W-1:0] quo_rnd;
  logic [SIM_W-1:0] sim_nxt;

  logic signed [SIM_W-1:0] sim_r;
  logic                    zn_r;

  function automatic logic signed [ACC_W-1:0] sat_acc(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [SUM_W-1:0] s;
    s = {{(SUM_W-ACC_W){acc[ACC_W-1]}}, acc} + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    if (s > SAT_HI)      sat_acc = SAT_HI[ACC_W-1:0];
    else if (s < SAT_LO) sat_acc = SAT_LO[ACC_W-1:0];
    else                 sat_acc = s[ACC_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prod_ab_r <= a_value * b_value;
      prod_aa_r <= a_value * a_value;
      prod_bb_r <= b_value * b_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p_valid_r <= 1'b0;
    else        p_valid_r <= cmd.take;
  end

  always_comb begin
    dot_nxt  = dot_r;
    ssq1_nxt = ssq1_r;
    ssq2_nxt = ssq2_r;
    if (cmd.load) begin
      dot_nxt  = '0;
      ssq1_nxt = '0;
      ssq2_nxt = '0;
    end else if (p_valid_r) begin
      dot_nxt  = sat_acc(dot_r, prod_ab_r);
      ssq1_nxt = sat_acc(ssq1_r, prod_aa_r);
      ssq2_nxt = sat_acc(ssq2_r, prod_bb_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= '0;
      ssq1_r <= '0;
      ssq2_r <= '0;
    end else begin
      dot_r  <= dot_nxt;
      ssq1_r <= ssq1_nxt;
      ssq2_r <= ssq2_nxt;
    end
  end

  assign status.zero = (ssq1_r == '0) || (ssq2_r == '0);

  // restoring square root, one result bit per lane per cycle
  always_comb begin
    t1       = res1_r + bit_r;
    t2       = res2_r + bit_r;
    x1_nxt   = x1_r;
    x2_nxt   = x2_r;
    res1_nxt = res1_r >> 1;
    res2_nxt = res2_r >> 1;
    if (x1_r >= t1) begin
      x1_nxt   = x1_r - t1;
      res1_nxt = (res1_r >> 1) + bit_r;
    end
    if (x2_r >= t2) begin
      x2_nxt   = x2_r - t2;
      res2_nxt = (res2_r >> 1) + bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1_r   <= {ssq1_r, {FRAC_SHIFT{1'b0}}};
      x2_r   <= {ssq2_r, {FRAC_SHIFT{1'b0}}};
      res1_r <= '0;
      res2_r <= '0;
      bit_r  <= SQ_BIT_INIT;
      neg_r  <= dot_r[ACC_W-1];
      mag_r  <= dot_r[ACC_W-1] ? ACC_W'(-dot_r) : ACC_W'(dot_r);
      zero_r <= status.zero;
    end else if (cmd.sq_step) begin
      x1_r   <= x1_nxt;
      x2_r   <= x2_nxt;
      res1_r <= res1_nxt;
      res2_r <= res2_nxt;
      bit_r  <= bit_r >> 2;
    end else if (cmd.div_step) begin
      mag_r  <= {mag_r[ACC_W-2:0], 1'b0};
    end
  end

  // restoring division, dividend bits from mag then zeros
  assign rem_sh = {rem_r, mag_r[ACC_W-1]};
  assign q_bit  = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      den_r <= res1_r[ROOT_W-1:0] * res2_r[ROOT_W-1:0];
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], q_bit};
    end
  end

  // round half away from zero, apply sign, saturate
  always_comb begin
    quo_inc = {1'b0, quo_r} + (QUO_W+1)'(1);
    quo_rnd = quo_inc[QUO_W:1];
    if (zero_r)
      sim_nxt = '0;
    else if (neg_r)
      sim_nxt = (quo_rnd > QUO_NEG_MAX) ? SIM_NEG_SAT : SIM_W'(-quo_rnd[SIM_W-1:0]);
    else
      sim_nxt = (quo_rnd > QUO_POS_MAX) ? SIM_POS_SAT : quo_rnd[SIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sim_r <= sim_nxt;
      zn_r  <= zero_r;
    end
  end

  assign similarity = sim_r;
  assign zero_norm  = zn_r;

endmodule

FILE: hw/rtl/cosine_similarity_unit_top.sv
// Cosine similarity of two vectors streamed as element pairs.
// in_ch  : one pair per transaction, a_value/b_value signed fixed point
//          (Q1.15 at ELEM_BITS = 16), last set on the final pair.
// out_ch : one transaction per vector pair: similarity in signed Q1.15,
//          saturated, and zero_norm when either vector has zero length
//          (similarity then reads 0).
// Throughput: one pair per cycle while accumulating; a product register
//   sits ahead of the three saturating 48-bit accumulators.
// Sequence: after the transaction carrying last, the result passes drain
//   and check, 32 square-root steps run on both norms at once, a multiply,
//   80 one-bit divide steps and a round, and then becomes valid.
//   For a zero-length vector it goes from check straight to the round.
//   in_ch.ready is low from the last pair until the result is loaded.
// Stall: the result sits in an output register; with it held, the next
//   vector is accepted and accumulated, and only its own result waits
//   for the register to free up.
// Reset (rst_n low, synchronous): sums cleared, no result pending.
module cosine_similarity_unit_top #(
  parameter int unsigned ELEM_BITS = csu_pkg::ELEM_BITS_DEF
) (
  input logic   clk,
  input logic   rst_n,
  csu_in_if.sink     in_ch,
  csu_out_if.source  out_ch
);
  import csu_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: handshakes, step counts, output valid
  csu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // products, accumulators, root lanes, divider, output payload
  csu_datapath #(
    .ELEM_BITS (ELEM_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .a_value    (in_ch.a_value),
    .b_value    (in_ch.b_value),
    .cmd        (cmd),
    .status     (status),
    .similarity (out_ch.similarity),
    .zero_norm  (out_ch.zero_norm)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  import csu_pkg::*;

  localparam int unsigned ELEM_BITS   = ELEM_BITS_DEF;
  localparam int          CYCLE_LIMIT = 1_000_000;  // whole run, several times the slowest pass
  localparam int          HOLD_CYCLES = 400;        // long receiver hold-off in the pressure phase
  localparam int          TAIL_CYCLES = 150;        // outlasts the result latency after the last pair

  // 48-bit signed accumulator rails
  localparam longint ACC_TOP = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_BOT = -ACC_TOP - 1;

  // shapes of the random vectors
  typedef enum int {
    VK_FREE,      // independent elements
    VK_PARALLEL,  // b equals a
    VK_OPPOSITE,  // b is -a
    VK_ZERO_A,    // first vector all zero
    VK_ZERO_B,    // second vector all zero
    VK_SCALED     // b is a shifted down, same direction
  } vec_kind_t;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] a;
    logic signed [ELEM_BITS-1:0] b;
    logic                        last;
  } pair_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] sim;
    logic                    zero;
  } sim_res_t;

  logic clk;
  logic rst_n;

  csu_in_if #(.ELEM_BITS(ELEM_BITS)) in_ch ();
  csu_out_if                         out_ch ();

  cosine_similarity_unit_top #(.ELEM_BITS(ELEM_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Clock: 2 ns period
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  pair_t    pending_pairs[$];   // pairs not yet offered to the block
  sim_res_t expected_sims[$];   // predicted similarity results, oldest first

  int   send_idle_pct;          // chance per free slot that the sender idles
  int   recv_stall_pct;         // chance per cycle that the receiver stalls
  logic pressure_go;            // starts the long receiver hold-off
  logic hold_off;               // receiver held off, counted in its own process
  int   mismatch_cnt = 0;
  int   result_idx   = 0;
  int   cycle_cnt    = 0;

  // predictor's copy of the three running sums
  longint dot_acc;
  longint sq_a_acc;
  longint sq_b_acc;

  pair_t    drv_pair;
  sim_res_t got_res;
  sim_res_t exp_res;

  // ---------------------------------------------------------------------------
  // Mismatch report: one line each, counted
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d, %0s: got %0d, expected %0d", result_idx, what, got, want);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Similarity predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp48(input longint s);
    if (s > ACC_TOP) return ACC_TOP;
    if (s < ACC_BOT) return ACC_BOT;
    return s;
  endfunction

  // floor square root, two radicand bits per step
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = x;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Fold one accepted pair into the sums; on the last pair, queue the result.
  task automatic fold_pair(input logic signed [ELEM_BITS-1:0] a,
                           input logic signed [ELEM_BITS-1:0] b,
                           input logic last);
    longint          av;
    longint          bv;
    longint          s;
    longint unsigned n1;
    longint unsigned n2;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    logic [127:0]    quo;
    sim_res_t        res;
    av = a;
    bv = b;
    dot_acc  = clamp48(dot_acc + av * bv);
    sq_a_acc = clamp48(sq_a_acc + av * av);
    sq_b_acc = clamp48(sq_b_acc + bv * bv);
    if (last) begin
      if (sq_a_acc == 0 || sq_b_acc == 0) begin
        // zero-length vector: flagged, similarity forced to 0
        res.sim  = '0;
        res.zero = 1'b1;
      end else begin
        // norms with 8 fraction bits each, product with 16
        n1  = floor_root(longint'(sq_a_acc) << FRAC_SHIFT);
        n2  = floor_root(longint'(sq_b_acc) << FRAC_SHIFT);
        den = n1 * n2;
        mag = (dot_acc < 0) ? longint'(-dot_acc) : longint'(dot_acc);
        quo = {64'd0, mag} << DIV_SCALE;
        quo = quo / {64'd0, den};
        q   = quo[63:0];
        q   = (q + 1) >> 1;   // round half away from zero on the magnitude
        if (dot_acc < 0) begin
          s = (q > 32768) ? -32768 : -longint'(q);
        end else begin
          s = (q > 32767) ? 32767 : longint'(q);
        end
        res.sim  = s[SIM_W-1:0];
        res.zero = 1'b0;
      end
      expected_sims.push_back(res);
      dot_acc  = 0;
      sq_a_acc = 0;
      sq_b_acc = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_pair(input int a, input int b, input logic last);
    pair_t p;
    p.a    = ELEM_BITS'(a);
    p.b    = ELEM_BITS'(b);
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  // extremes, zero and tiny values often, otherwise the full range
  function automatic logic signed [ELEM_BITS-1:0] pick_elem();
    int tmp;
    tmp = $urandom_range(0, 8);
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(ELEM_BITS-1){1'b0}}};
      1:       return {1'b0, {(ELEM_BITS-1){1'b1}}};
      2:       return '0;
      3:       return ELEM_BITS'(tmp - 4);
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_vector(input vec_kind_t kind, input int len);
    pair_t p;
    int    i;
    int    sh;
    sh = $urandom_range(0, 6);
    for (i = 0; i < len; i++) begin
      p.a = pick_elem();
      p.b = pick_elem();
      case (kind)
        VK_PARALLEL: p.b = p.a;
        VK_OPPOSITE: p.b = -p.a;
        VK_ZERO_A:   p.a = '0;
        VK_ZERO_B:   p.b = '0;
        VK_SCALED:   p.b = p.a >>> sh;
        default:     ;
      endcase
      p.last = (i == len - 1);
      pending_pairs.push_back(p);
    end
  endtask

  // random vectors, mostly short, now and then a longer one
  task automatic queue_random(input int n_pairs);
    int        added;
    int        len;
    vec_kind_t kind;
    added = 0;
    while (added < n_pairs) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
      case ($urandom_range(0, 11))
        0:       kind = VK_PARALLEL;
        1:       kind = VK_OPPOSITE;
        2:       kind = VK_ZERO_A;
        3:       kind = VK_ZERO_B;
        4, 5:    kind = VK_SCALED;
        default: kind = VK_FREE;
      endcase
      queue_vector(kind, len);
      added += len;
    end
  endtask

  // wait until every pair went in and every result came out
  task automatic drain_all();
    while (pending_pairs.size() != 0 || in_ch.valid || expected_sims.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending pairs, holds each until its transaction completes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_pair = pending_pairs.pop_front();
        in_ch.a_value <= drv_pair.a;
        in_ch.b_value <= drv_pair.b;
        in_ch.last    <= drv_pair.last;
        in_ch.valid   <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      fold_pair(in_ch.a_value, in_ch.b_value, in_ch.last);
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, forced low during the hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Long hold-off while the sender keeps offering; the output register and
  // the next vector's result fill up, so in_ch.ready must drop.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_res.sim  = out_ch.similarity;
      got_res.zero = out_ch.zero_norm;
      if (expected_sims.size() == 0) begin
        note_mismatch("unexpected result, similarity", got_res.sim, 0);
      end else begin
        exp_res = expected_sims.pop_front();
        if (got_res.sim !== exp_res.sim)
          note_mismatch("similarity", got_res.sim, exp_res.sim);
        if (got_res.zero !== exp_res.zero)
          note_mismatch("zero_norm", got_res.zero, exp_res.zero);
      end
      result_idx++;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.a_value  = '0;
    in_ch.b_value  = '0;
    in_ch.last     = 1'b0;
    out_ch.ready   = 1'b0;
    hold_off       = 1'b0;
    pressure_go    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    dot_acc        = 0;
    sq_a_acc       = 0;
    sq_b_acc       = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase 0, no idling: directed cases first.
    push_pair( 32767,  32767, 1'b1);   // parallel at the top, ratio 1.0 saturates
    push_pair(-32768, -32768, 1'b1);   // parallel at the bottom
    push_pair(-32768,  32767, 1'b1);   // opposite extremes
    push_pair(     1,     -1, 1'b1);   // tiny opposite, rounds onto -1.0
    push_pair(     0,      0, 1'b1);   // both vectors zero length
    push_pair(     0,      5, 1'b1);   // first vector zero length
    push_pair(     7,      0, 1'b1);   // second vector zero length
    push_pair(     1,      0, 1'b0);   // orthogonal three-element vectors
    push_pair(     0,      1, 1'b0);
    push_pair(     0,      0, 1'b1);
    push_pair( 32767, -32768, 1'b0);   // mixed extremes, four elements
    push_pair(-32768,  32767, 1'b0);
    push_pair(   100,   -100, 1'b0);
    push_pair(     1,      1, 1'b1);
    push_pair(     0,      3, 1'b0);   // zero first vector over several pairs
    push_pair(     0,     -3, 1'b0);
    push_pair(     0,      0, 1'b1);
    push_pair(  3000,   1000, 1'b0);   // ordinary mid-range similarity
    push_pair( -2000,   4000, 1'b1);

    queue_random(300);
    drain_all();

    // Phase 1: sender idles 70% of the time
    send_idle_pct  = 70;
    recv_stall_pct = 0;
    queue_random(300);
    drain_all();

    // Phase 2: receiver stalls 70% of the time
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    queue_random(300);
    drain_all();

    // Phase 3: both sides idle 34% of the time
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    queue_random(300);
    drain_all();

    // Phase 4: back pressure; long receiver hold-off, sender never idles
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(150);
    pressure_go    = 1'b1;
    drain_all();

    // let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_sims.size() != 0)
      note_mismatch("results never seen", expected_sims.size(), 0);

    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
